[src/framed_crc_receiver_with_ack_assert.svh]
// Assertion macros for the frame receiver.
`ifndef FRAMED_CRC_RECEIVER_WITH_ACK_ASSERT_SVH
`define FRAMED_CRC_RECEIVER_WITH_ACK_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FCRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FCRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/fcrc_pkg.sv]
package fcrc_pkg;

  localparam logic [7:0]  SYNC_A      = 8'hAA;
  localparam logic [7:0]  SYNC_B      = 8'h55;
  localparam logic [7:0]  TYPE_DATA   = 8'h02;
  localparam logic [7:0]  TYPE_FINISH = 8'h04;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] TICK_MAX    = 16'hFFFF;

  localparam logic [15:0] EXP_LEN_RST = 16'd401;
  localparam logic [15:0] REQ_PER_RST = 16'd20;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_PER = 1'b1;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_ACK     = 2'd1;
  localparam logic [1:0] KIND_REQ     = 2'd2;
  localparam logic [1:0] KIND_FINISH  = 2'd3;

  typedef enum logic [9:0] {
    PH_SYNC0 = 10'b00_0000_0001,
    PH_SYNC1 = 10'b00_0000_0010,
    PH_TYPE  = 10'b00_0000_0100,
    PH_SEQ0  = 10'b00_0000_1000,
    PH_SEQ1  = 10'b00_0001_0000,
    PH_LEN0  = 10'b00_0010_0000,
    PH_LEN1  = 10'b00_0100_0000,
    PH_DATA  = 10'b00_1000_0000,
    PH_CRC0  = 10'b01_0000_0000,
    PH_CRC1  = 10'b10_0000_0000
  } phase_t;

  // One queued job; 'two' means a request for seq+1 follows the ack.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  pbyte;
    logic [15:0] pidx;
    logic [15:0] seq;
    logic        err;
    logic        acc;
    logic        two;
  } fcrc_entry_t;

  typedef struct packed {
    logic        push;
    fcrc_entry_t entry;
  } fcrc_push_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

[src/fcrc_if.sv]
interface fcrc_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;
  modport source (output valid, command, rx_byte, input ready);
  modport sink   (input valid, command, rx_byte, output ready);
endinterface

interface fcrc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic [15:0] sequence_res;
  logic        ack_error;
  logic        accepted_new;
  logic        last;
  modport source (output valid, kind, payload_byte, payload_index, sequence_res,
                  ack_error, accepted_new, last, input ready);
  modport sink   (input valid, kind, payload_byte, payload_index, sequence_res,
                  ack_error, accepted_new, last, output ready);
endinterface

interface fcrc_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/fcrc_front.sv]
module fcrc_front import fcrc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_acc,
  input  logic                 command,
  input  logic [7:0]           rx_byte,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [15:0]          cfg_data,
  output fcrc_push_t           push_o,
  output logic                 idle_o
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [15:0] exp_seq_r, exp_seq_nxt;
  logic        idle_r, idle_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  logic [15:0] exp_len_r, req_per_r;

  logic [15:0] tick_inc;
  logic [15:0] crc_upd;
  logic [15:0] rx_crc;
  logic [15:0] len_full;
  fcrc_push_t  p;

  assign tick_inc = (ticks_r == TICK_MAX) ? ticks_r : ticks_r + 16'd1;
  assign crc_upd  = crc_byte((phase_r == PH_TYPE) ? CRC_INIT : crc_r, rx_byte);
  assign rx_crc   = {rx_byte, crc_lo_r};
  assign len_full = {rx_byte, len_r[7:0]};

  always_comb begin
    phase_nxt   = phase_r;
    type_nxt    = type_r;
    seq_nxt     = seq_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    crc_nxt     = crc_r;
    crc_lo_nxt  = crc_lo_r;
    exp_seq_nxt = exp_seq_r;
    idle_nxt    = idle_r;
    ticks_nxt   = ticks_r;
    p           = '0;

    if (in_acc && !idle_r) begin
      if (command) begin
        if (tick_inc >= req_per_r) begin
          ticks_nxt     = '0;
          p.push        = 1'b1;
          p.entry.kind  = KIND_REQ;
          p.entry.seq   = exp_seq_r;
        end else begin
          ticks_nxt = tick_inc;
        end
      end else begin
        unique case (phase_r)
          PH_SYNC1: begin
            phase_nxt = (rx_byte == SYNC_B) ? PH_TYPE : PH_SYNC0;
          end
          PH_TYPE: begin
            type_nxt  = rx_byte;
            crc_nxt   = crc_upd;
            phase_nxt = PH_SEQ0;
          end
          PH_SEQ0: begin
            seq_nxt   = {8'h00, rx_byte};
            crc_nxt   = crc_upd;
            phase_nxt = PH_SEQ1;
          end
          PH_SEQ1: begin
            seq_nxt   = {rx_byte, seq_r[7:0]};
            crc_nxt   = crc_upd;
            phase_nxt = PH_LEN0;
          end
          PH_LEN0: begin
            len_nxt   = {8'h00, rx_byte};
            crc_nxt   = crc_upd;
            phase_nxt = PH_LEN1;
          end
          PH_LEN1: begin
            len_nxt = len_full;
            crc_nxt = crc_upd;
            cnt_nxt = '0;
            if (len_full > exp_len_r) begin
              phase_nxt = PH_SYNC0;
            end else if (len_full == 16'd0) begin
              phase_nxt = PH_CRC0;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
          PH_DATA: begin
            p.push        = 1'b1;
            p.entry.kind  = KIND_PAYLOAD;
            p.entry.pbyte = rx_byte;
            p.entry.pidx  = cnt_r;
            crc_nxt       = crc_upd;
            cnt_nxt       = cnt_r + 16'd1;
            if (cnt_nxt >= len_r) begin
              phase_nxt = PH_CRC0;
            end
          end
          PH_CRC0: begin
            crc_lo_nxt = rx_byte;
            phase_nxt  = PH_CRC1;
          end
          PH_CRC1: begin
            phase_nxt   = PH_SYNC0;
            p.entry.seq = seq_r;
            priority if (rx_crc != crc_r) begin
              p.push       = 1'b1;
              p.entry.kind = KIND_ACK;
              p.entry.err  = 1'b1;
            end else if (type_r == TYPE_FINISH) begin
              idle_nxt     = 1'b1;
              p.push       = 1'b1;
              p.entry.kind = KIND_FINISH;
            end else if (type_r != TYPE_DATA) begin
              p.push = 1'b0;
            end else if (len_r != exp_len_r) begin
              p.push       = 1'b1;
              p.entry.kind = KIND_ACK;
              p.entry.err  = 1'b1;
            end else if (seq_r == exp_seq_r) begin
              p.push       = 1'b1;
              p.entry.kind = KIND_ACK;
              p.entry.acc  = 1'b1;
              p.entry.two  = 1'b1;
              exp_seq_nxt  = exp_seq_r + 16'd1;
              ticks_nxt    = '0;
            end else if (seq_r < exp_seq_r) begin
              p.push       = 1'b1;
              p.entry.kind = KIND_ACK;
            end else begin
              p.push       = 1'b1;
              p.entry.kind = KIND_ACK;
              p.entry.err  = 1'b1;
            end
          end
          default: begin
            // first sync byte; stray codes land here too
            phase_nxt = (rx_byte == SYNC_A) ? PH_SYNC1 : PH_SYNC0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_SYNC0;
      type_r    <= '0;
      seq_r     <= '0;
      len_r     <= '0;
      cnt_r     <= '0;
      crc_r     <= CRC_INIT;
      crc_lo_r  <= '0;
      exp_seq_r <= '0;
      idle_r    <= 1'b0;
      ticks_r   <= '0;
      exp_len_r <= EXP_LEN_RST;
      req_per_r <= REQ_PER_RST;
    end else begin
      phase_r   <= phase_nxt;
      type_r    <= type_nxt;
      seq_r     <= seq_nxt;
      len_r     <= len_nxt;
      cnt_r     <= cnt_nxt;
      crc_r     <= crc_nxt;
      crc_lo_r  <= crc_lo_nxt;
      exp_seq_r <= exp_seq_nxt;
      idle_r    <= idle_nxt;
      ticks_r   <= ticks_nxt;
      if (cfg_we && cfg_idx == CFG_EXP_LEN) begin
        exp_len_r <= cfg_data;
      end
      if (cfg_we && cfg_idx == CFG_REQ_PER) begin
        req_per_r <= cfg_data;
      end
    end
  end

  assign push_o = p;
  assign idle_o = idle_r;

endmodule

[src/fcrc_queue.sv]
module fcrc_queue import fcrc_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  fcrc_push_t  push_i,
  input  logic        pop,
  output fcrc_entry_t head,
  output logic        not_empty,
  output logic        full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fcrc_entry_t        slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push_i.push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_i.entry;
    end
  end

endmodule

[src/fcrc_back.sv]
module fcrc_back import fcrc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  fcrc_entry_t head,
  input  logic        not_empty,
  output logic        pop,
  input  logic        out_ready,
  output logic        out_valid,
  output fcrc_entry_t out_res,
  output logic        out_last
);

  logic        valid_r, valid_nxt;
  logic        pend_r, pend_nxt;
  logic [15:0] req_seq_r, req_seq_nxt;
  fcrc_entry_t res_r, res_nxt;
  logic        last_r, last_nxt;
  logic        load;

  assign load = !valid_r || out_ready;

  always_comb begin
    valid_nxt   = valid_r;
    pend_nxt    = pend_r;
    req_seq_nxt = req_seq_r;
    res_nxt     = res_r;
    last_nxt    = last_r;
    pop         = 1'b0;
    if (load) begin
      if (pend_r) begin
        // request that trails a good new-frame ack
        valid_nxt    = 1'b1;
        pend_nxt     = 1'b0;
        res_nxt      = '0;
        res_nxt.kind = KIND_REQ;
        res_nxt.seq  = req_seq_r;
        last_nxt     = 1'b1;
      end else if (not_empty) begin
        pop         = 1'b1;
        valid_nxt   = 1'b1;
        res_nxt     = head;
        last_nxt    = !head.two;
        pend_nxt    = head.two;
        req_seq_nxt = head.seq + 16'd1;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_seq_r <= req_seq_nxt;
    res_r     <= res_nxt;
    last_r    <= last_nxt;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;
  assign out_last  = last_r;

endmodule

[src/framed_crc_receiver_with_ack.sv]
// Channel  | Dir | Payload                                        | Transaction when
// in_ch    | in  | command, rx_byte                               | valid & ready
// out_ch   | out | kind, payload_byte, payload_index,            | valid & ready
//          |     | sequence_res, ack_error, accepted_new, last    |
// cfg_ch   | in  | index, data                                    | valid & ready
//
// One input transaction per cycle while the queue has room; each is parsed as accepted.
// Results leave the output register at one per cycle while out_ch.ready holds; a good
// new data frame yields an ack then a request, so the result side sets the peak rate.
// in_ch.ready drops only while the QUEUE_DEPTH-entry job queue is full.
// Reset is synchronous: parse state, sequence, tick counter, queue and output valid clear.
// cfg_ch is always ready; each accepted write updates its register directly.
`include "framed_crc_receiver_with_ack_assert.svh"

module framed_crc_receiver_with_ack import fcrc_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  fcrc_in_if.sink   in_ch,
  fcrc_out_if.source out_ch,
  fcrc_cfg_if.sink  cfg_ch
);

  fcrc_push_t  q_push;
  fcrc_entry_t q_head;
  fcrc_entry_t out_res;
  logic        q_not_empty;
  logic        q_full;
  logic        q_pop;
  logic        in_acc;
  logic        cfg_we;
  logic        front_idle;

  // Front side: take bytes/ticks whenever the queue has room.
  assign in_ch.ready  = !q_full;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid && cfg_ch.ready;

  // Parser, CRC, sequence tracking and request timer.
  fcrc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_acc   (in_acc),
    .command  (in_ch.command),
    .rx_byte  (in_ch.rx_byte),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_ch.index),
    .cfg_data (cfg_ch.data),
    .push_o   (q_push),
    .idle_o   (front_idle)
  );

  // Decouples parser from downstream backpressure.
  fcrc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (q_push),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // Expands jobs into result transactions behind an output register.
  fcrc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_res   (out_res),
    .out_last  (out_ch.last)
  );

  assign out_ch.kind          = out_res.kind;
  assign out_ch.payload_byte  = out_res.pbyte;
  assign out_ch.payload_index = out_res.pidx;
  assign out_ch.sequence_res  = out_res.seq;
  assign out_ch.ack_error     = out_res.err;
  assign out_ch.accepted_new  = out_res.acc;

  // A job is only generated for an accepted input, which requires queue room.
  `FCRC_ASSERT_NOW(a_push_has_room, q_push.push, !q_full && in_acc, "push without room")
  // Nothing new is queued once a finish frame idled the parser.
  `FCRC_ASSERT_NOW(a_idle_quiet, front_idle, !q_push.push, "job queued while idle")
  // A non-last ack is always followed by its request.
  `FCRC_ASSERT_NEXT(a_ack_then_req, out_ch.valid && out_ch.ready && !out_ch.last,
                    out_ch.valid && out_ch.kind == KIND_REQ && out_ch.last,
                    "request missing after new-frame ack")
  // accepted_new only on a good ack.
  `FCRC_ASSERT_NOW(a_acc_good, out_ch.valid && out_ch.accepted_new,
                   out_ch.kind == KIND_ACK && !out_ch.ack_error, "bad accepted_new")

endmodule

[tb/sv/tb_framed_crc_receiver_with_ack.sv]
`timescale 1ns / 1ps

module tb_framed_crc_receiver_with_ack;
  import fcrc_pkg::*;

  localparam int   IDLE_LIMIT   = 2000;  // cycles without any transaction
  localparam int   MAX_WAIT     = 18;
  localparam int   DRAIN_CYCLES = 12;    // covers the job queue plus output register
  localparam int   HOLD_CYCLES  = 90;    // long receiver back-pressure
  localparam logic CMD_BYTE     = 1'b0;
  localparam logic CMD_TICK     = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } link_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  pbyte;
    logic [15:0] pidx;
    logic [15:0] seq;
    logic        err;
    logic        acc;
    logic        last;
  } rx_result_t;

  logic clk = 1'b0;
  logic rst_n;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  fcrc_in_if  in_if ();
  fcrc_out_if out_if ();
  fcrc_cfg_if cfg_if ();

  framed_crc_receiver_with_ack u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // ---------------------------------------------------------------------------
  // Receiver shadow state, advanced once per accepted input transaction
  // ---------------------------------------------------------------------------
  phase_t      rx_phase   = PH_SYNC0;
  logic [7:0]  rx_type    = '0;
  logic [15:0] rx_seq     = '0;
  logic [15:0] rx_len     = '0;
  logic [15:0] rx_count   = '0;
  logic [15:0] rx_crc     = CRC_INIT;
  logic [7:0]  rx_crc_lo  = '0;
  logic [15:0] want_seq   = '0;       // next sequence the receiver will keep
  logic        halted     = 1'b0;     // set by a good finish frame
  logic [15:0] tick_count = '0;
  logic [15:0] exp_len    = EXP_LEN_RST;
  logic [15:0] req_period = REQ_PER_RST;

  rx_result_t  due_results[$];        // results still owed by the block
  link_item_t  link_queue[$];         // bytes and ticks not yet offered

  // Stimulus side view: settings the generator plans against
  logic [15:0] gen_len   = EXP_LEN_RST;
  logic [15:0] gen_seq   = '0;
  int          items_sent = 0;

  int          errors = 0;
  logic        in_fire  = 1'b0;
  logic        out_fire = 1'b0;
  int          in_gap = 0;
  bit          in_calm = 1'b0;
  int          out_wait = 0;
  bit          out_calm = 1'b0;
  int          hold_left = 0;
  int          results_seen = 0;
  int          idle_cycles = 0;
  rx_result_t  seen_result;
  rx_result_t  due_result;

  // CRC-16/CCITT, one bit per step, MSB first
  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ data[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic void emit(input logic [1:0] kind, input logic [7:0] pbyte,
                               input logic [15:0] pidx, input logic [15:0] seq,
                               input logic err, input logic acc, input logic last);
    due_results.push_back('{kind, pbyte, pidx, seq, err, acc, last});
  endfunction

  // Decision taken when the CRC high byte lands
  function automatic void close_frame(input logic [7:0] crc_hi);
    if ({crc_hi, rx_crc_lo} != rx_crc) begin
      emit(KIND_ACK, 8'h00, 16'h0000, rx_seq, 1'b1, 1'b0, 1'b1);
    end else if (rx_type == TYPE_FINISH) begin
      halted = 1'b1;
      emit(KIND_FINISH, 8'h00, 16'h0000, rx_seq, 1'b0, 1'b0, 1'b1);
    end else if (rx_type == TYPE_DATA) begin
      if (rx_len != exp_len) begin
        emit(KIND_ACK, 8'h00, 16'h0000, rx_seq, 1'b1, 1'b0, 1'b1);
      end else if (rx_seq == want_seq) begin
        // new packet: good ack, then request the one after it
        emit(KIND_ACK, 8'h00, 16'h0000, rx_seq, 1'b0, 1'b1, 1'b0);
        want_seq   = want_seq + 16'd1;
        tick_count = '0;
        emit(KIND_REQ, 8'h00, 16'h0000, want_seq, 1'b0, 1'b0, 1'b1);
      end else if (rx_seq < want_seq) begin
        // repeat of an old packet: acked good, nothing kept
        emit(KIND_ACK, 8'h00, 16'h0000, rx_seq, 1'b0, 1'b0, 1'b1);
      end else begin
        emit(KIND_ACK, 8'h00, 16'h0000, rx_seq, 1'b1, 1'b0, 1'b1);
      end
    end
    // any other frame type is dropped silently
  endfunction

  function automatic void receiver_step(input link_item_t item);
    logic [7:0] b;
    b = item.rx_byte;
    if (halted) return;
    if (item.command == CMD_TICK) begin
      if (tick_count != TICK_MAX) tick_count = tick_count + 16'd1;
      if (tick_count >= req_period) begin
        tick_count = '0;
        emit(KIND_REQ, 8'h00, 16'h0000, want_seq, 1'b0, 1'b0, 1'b1);
      end
      return;
    end
    case (rx_phase)
      PH_SYNC1: rx_phase = (b == SYNC_B) ? PH_TYPE : PH_SYNC0;
      PH_TYPE: begin
        rx_type  = b;
        rx_crc   = crc16_next(CRC_INIT, b);
        rx_phase = PH_SEQ0;
      end
      PH_SEQ0: begin
        rx_seq   = {8'h00, b};
        rx_crc   = crc16_next(rx_crc, b);
        rx_phase = PH_SEQ1;
      end
      PH_SEQ1: begin
        rx_seq[15:8] = b;
        rx_crc       = crc16_next(rx_crc, b);
        rx_phase     = PH_LEN0;
      end
      PH_LEN0: begin
        rx_len   = {8'h00, b};
        rx_crc   = crc16_next(rx_crc, b);
        rx_phase = PH_LEN1;
      end
      PH_LEN1: begin
        rx_len[15:8] = b;
        rx_crc       = crc16_next(rx_crc, b);
        rx_count     = '0;
        if (rx_len > exp_len) rx_phase = PH_SYNC0;
        else rx_phase = (rx_len == 16'h0000) ? PH_CRC0 : PH_DATA;
      end
      PH_DATA: begin
        emit(KIND_PAYLOAD, b, rx_count, 16'h0000, 1'b0, 1'b0, 1'b1);
        rx_crc   = crc16_next(rx_crc, b);
        rx_count = rx_count + 16'd1;
        if (rx_count >= rx_len) rx_phase = PH_CRC0;
      end
      PH_CRC0: begin
        rx_crc_lo = b;
        rx_phase  = PH_CRC1;
      end
      PH_CRC1: begin
        rx_phase = PH_SYNC0;
        close_frame(b);
      end
      default: rx_phase = (b == SYNC_A) ? PH_SYNC1 : PH_SYNC0;
    endcase
  endfunction

  function automatic string show(input rx_result_t r);
    return $sformatf("kind %0d byte %02h index %0d seq %0d err %0b new %0b last %0b",
                     r.kind, r.pbyte, r.pidx, r.seq, r.err, r.acc, r.last);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  function automatic void push_byte(input logic [7:0] b);
    link_queue.push_back('{CMD_BYTE, b});
    items_sent++;
  endfunction

  function automatic void push_tick();
    link_queue.push_back('{CMD_TICK, 8'($urandom)});
    items_sent++;
  endfunction

  // frame byte, sometimes followed by a tick that can land mid-frame
  function automatic void frame_byte(input logic [7:0] b);
    push_byte(b);
    if ($urandom_range(0, 7) == 0) push_tick();
  endfunction

  function automatic void queue_frame(input logic [7:0] ftype, input logic [15:0] seq,
                                      input logic [15:0] len, input bit bad_crc);
    logic [7:0]  field[5];
    logic [7:0]  data;
    logic [15:0] crc;
    field = '{ftype, seq[7:0], seq[15:8], len[7:0], len[15:8]};
    crc   = CRC_INIT;
    frame_byte(SYNC_A);
    frame_byte(SYNC_B);
    foreach (field[i]) begin
      crc = crc16_next(crc, field[i]);
      frame_byte(field[i]);
    end
    // over-long: the receiver drops it right after the length field
    if (len > gen_len) return;
    for (int i = 0; i < len; i++) begin
      data = 8'($urandom);
      crc  = crc16_next(crc, data);
      frame_byte(data);
    end
    if (bad_crc) crc ^= 16'($urandom_range(1, 16'hFFFF));
    frame_byte(crc[7:0]);
    frame_byte(crc[15:8]);
    if (ftype == TYPE_DATA && seq == gen_seq && len == gen_len && !bad_crc)
      gen_seq++;
  endfunction

  // Half the picks are in-order data frames; the rest are repeats, future sequences,
  // damaged frames, wrong lengths, odd types, bad sync and line noise. Every choice keeps
  // the parser aligned on frame boundaries.
  function automatic void random_sequence();
    int          pick;
    logic [15:0] len_ok;
    logic [15:0] seq;
    logic [7:0]  val;
    pick   = $urandom_range(0, 99);
    len_ok = (gen_len <= 16'd16) ? gen_len : 16'($urandom_range(0, 8));
    seq    = 16'($urandom);
    if (pick < 50) begin
      queue_frame(TYPE_DATA, gen_seq, len_ok, 1'b0);
    end else if (pick < 60 && gen_seq != 0) begin
      queue_frame(TYPE_DATA, 16'($urandom_range(0, int'(gen_seq) - 1)), len_ok, 1'b0);
    end else if (pick < 67) begin
      seq = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                         : 16'($urandom_range(int'(gen_seq) + 1, 16'hFFFF));
      queue_frame(TYPE_DATA, seq, len_ok, 1'b0);
    end else if (pick < 74) begin
      queue_frame($urandom_range(0, 1) ? TYPE_DATA : TYPE_FINISH, seq, len_ok, 1'b1);
    end else if (pick < 80 && gen_len != 0) begin
      queue_frame(TYPE_DATA, gen_seq,
                  16'($urandom_range(0, (gen_len > 16) ? 16 : int'(gen_len) - 1)), 1'b0);
    end else if (pick < 85) begin
      do val = 8'($urandom); while (val == TYPE_DATA || val == TYPE_FINISH);
      queue_frame(val, seq, len_ok, 1'b0);
    end else if (pick < 90 && gen_len != 16'hFFFF) begin
      queue_frame(TYPE_DATA, seq,
                  $urandom_range(0, 1) ? 16'hFFFF
                                       : 16'($urandom_range(int'(gen_len) + 1, 16'hFFFF)),
                  1'b0);
    end else if (pick < 95) begin
      // first sync byte followed by a wrong second one
      push_byte(SYNC_A);
      do val = 8'($urandom); while (val == SYNC_B || val == SYNC_A);
      push_byte(val);
    end else begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 1)) begin
          push_tick();
        end else begin
          do val = 8'($urandom); while (val == SYNC_A);
          push_byte(val);
        end
      end
    end
  endfunction

  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Waits until every offered item went in and every owed result came out,
  // then lets the pipeline settle (frames of ignored types owe nothing).
  task automatic wait_drained();
    while (link_queue.size() != 0 || in_if.valid || due_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] len_cfg, input logic [15:0] per_cfg,
                           input int budget);
    int first;
    wait_drained();
    write_cfg(CFG_EXP_LEN, len_cfg);
    write_cfg(CFG_REQ_PER, per_cfg);
    gen_len = len_cfg;
    first   = items_sent;
    while (items_sent - first < budget) random_sequence();
  endtask

  // ---------------------------------------------------------------------------
  // Rising edge: record transactions, predict, then check results
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    in_fire  <= rst_n && in_if.valid && in_if.ready;
    out_fire <= rst_n && out_if.valid && out_if.ready;
    if (rst_n && cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.index)
        CFG_EXP_LEN: exp_len    = cfg_if.data;
        CFG_REQ_PER: req_period = cfg_if.data;
        default: ;
      endcase
    end
    // prediction first so a same-cycle result would still find its entry
    if (rst_n && in_if.valid && in_if.ready)
      receiver_step('{in_if.command, in_if.rx_byte});
    if (rst_n && out_if.valid && out_if.ready) begin
      seen_result = '{out_if.kind, out_if.payload_byte, out_if.payload_index,
                      out_if.sequence_res, out_if.ack_error, out_if.accepted_new,
                      out_if.last};
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected nothing, actual %s",
                 $time, show(seen_result));
        errors++;
      end else begin
        due_result = due_results.pop_front();
        if (seen_result !== due_result) begin
          $display("%0t: result mismatch, expected %s, actual %s",
                   $time, show(due_result), show(seen_result));
          errors++;
        end
      end
    end
  end

  // Input driver: one item per transaction, random gaps between items
  always @(negedge clk) begin
    link_item_t item;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_fire) begin
      if (in_gap > 0) begin
        in_gap--;
        in_if.valid <= 1'b0;
      end else if (link_queue.size() != 0) begin
        item = link_queue.pop_front();
        in_if.valid   <= 1'b1;
        in_if.command <= item.command;
        in_if.rx_byte <= item.rx_byte;
        in_gap = draw_wait(in_calm);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result side ready: random stalls after each transaction, plus two long
  // holds so the job queue fills and the input side gets back-pressured
  always @(negedge clk) begin
    if (out_fire) begin
      results_seen++;
      out_wait = draw_wait(out_calm);
      if (results_seen == 60 || results_seen == 260) hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (out_wait > 0) begin
      out_wait--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Watchdog: too long without any transaction on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.command  = CMD_BYTE;
    in_if.rx_byte  = 8'h00;
    out_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = CFG_EXP_LEN;
    cfg_if.data    = 16'h0000;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty payloads, request on every tick
    write_cfg(CFG_EXP_LEN, 16'd0);
    write_cfg(CFG_REQ_PER, 16'd1);
    gen_len = 16'd0;
    push_tick();                                       // request for sequence 0
    queue_frame(TYPE_DATA, 16'h0000, 16'h0000, 1'b0);  // empty payload, new packet
    queue_frame(TYPE_DATA, 16'hFFFF, 16'hFFFF, 1'b0);  // over-long, header only
    push_byte(SYNC_A);                                 // bad second sync byte
    push_byte(8'h00);
    push_byte(8'hFF);

    // Random phases, each with its own register settings
    run_phase(16'd5,     16'd1,     70);
    run_phase(16'd0,     16'd0,     50);   // zero period: request on every tick
    run_phase(16'd8,     16'hFFFF,  60);   // requests only after new packets
    run_phase(16'hFFFF,  16'd4,     60);   // nothing can be over-long
    run_phase(16'd16,    16'd3,     80);
    run_phase(16'd1,     16'd7,     60);
    run_phase(16'd6,     16'd12,    60);

    // Good finish frame: everything after it is ignored
    wait_drained();
    queue_frame(TYPE_FINISH, 16'($urandom), 16'h0000, 1'b0);
    queue_frame(TYPE_DATA, gen_seq, gen_len, 1'b0);
    repeat (25) push_tick();

    wait_drained();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/fcrc_pkg.sv
src/fcrc_if.sv
src/fcrc_front.sv
src/fcrc_queue.sv
src/fcrc_back.sv
src/framed_crc_receiver_with_ack.sv
tb/sv/tb_framed_crc_receiver_with_ack.sv
